// ===== hdl/cce_pkg.sv =====
// Package for the control character escape stream block.
// Holds widths, the load record between expander and emitter, and the expansion function.
// No dependencies.
package cce_pkg;

    localparam int LEN_W  = 16;
    localparam int SEQ_N  = 5;
    localparam int SEQ_W  = SEQ_N * 8;
    localparam int CNT_W  = 3;

    localparam logic [LEN_W-1:0] BUF_SIZE_RST = LEN_W'(256);

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [CNT_W-1:0] len;
    } t_expansion;

    typedef struct packed {
        logic             load;
        logic [SEQ_W-1:0] seq;
        logic [CNT_W-1:0] len;
        logic             report;
        logic             last;
        logic [LEN_W-1:0] base;
    } t_load;

    typedef struct packed {
        logic [23:0] chars;
        logic        three;
    } t_ctrl_name;

    function automatic t_ctrl_name ctrl_name(input logic [4:0] code);
        t_ctrl_name r;
        r.three = 1'b1;
        unique case (code)
            5'd0:  r.chars = "NUL";
            5'd1:  r.chars = "SOH";
            5'd2:  r.chars = "STX";
            5'd3:  r.chars = "ETX";
            5'd4:  r.chars = "EOT";
            5'd5:  r.chars = "ENQ";
            5'd6:  r.chars = "ACK";
            5'd7:  r.chars = "BEL";
            5'd8:  r.chars = "BS ";
            5'd9:  r.chars = "HT ";
            5'd10: r.chars = "LF ";
            5'd11: r.chars = "VT ";
            5'd12: r.chars = "FF ";
            5'd13: r.chars = "CR ";
            5'd14: r.chars = "SO ";
            5'd15: r.chars = "SI ";
            5'd16: r.chars = "DLE";
            5'd17: r.chars = "DC1";
            5'd18: r.chars = "DC2";
            5'd19: r.chars = "DC3";
            5'd20: r.chars = "DC4";
            5'd21: r.chars = "NAK";
            5'd22: r.chars = "SYN";
            5'd23: r.chars = "ETB";
            5'd24: r.chars = "CAN";
            5'd25: r.chars = "EM ";
            5'd26: r.chars = "SUB";
            5'd27: r.chars = "ESC";
            5'd28: r.chars = "FS ";
            5'd29: r.chars = "GS ";
            5'd30: r.chars = "RS ";
            5'd31: r.chars = "US ";
            default: r.chars = "NUL";
        endcase
        if (r.chars[7:0] == 8'h20) begin
            r.three = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10) begin
            r = 8'h30 + {4'd0, d};
        end else begin
            r = 8'h57 + {4'd0, d};
        end
        return r;
    endfunction

    // byte 0 of seq sits in bits [7:0] and is emitted first
    function automatic t_expansion expand(input logic [7:0] b);
        t_expansion r;
        t_ctrl_name nm;
        nm    = ctrl_name(b[4:0]);
        r.seq = '0;
        r.len = CNT_W'(1);
        if (b == 8'h09 || b == 8'h0A || b == 8'h0D || (b >= 8'h20 && b <= 8'h7E)) begin
            r.seq[7:0] = b;
        end else if (b < 8'h20) begin
            r.seq[7:0]   = "<";
            r.seq[15:8]  = nm.chars[23:16];
            r.seq[23:16] = nm.chars[15:8];
            if (nm.three) begin
                r.seq[31:24] = nm.chars[7:0];
                r.seq[39:32] = ">";
                r.len        = CNT_W'(5);
            end else begin
                r.seq[31:24] = ">";
                r.len        = CNT_W'(4);
            end
        end else if (b == 8'h7F) begin
            r.seq = {">", "L", "E", "D", "<"};
            r.len = CNT_W'(5);
        end else begin
            r.seq[7:0]   = "<";
            r.seq[15:8]  = hex_char(b[7:4]);
            r.seq[23:16] = hex_char(b[3:0]);
            r.seq[31:24] = ">";
            r.len        = CNT_W'(4);
        end
        return r;
    endfunction

endpackage

// ===== hdl/cce_if.sv =====
// Channel interfaces for the control character escape stream block.
// Depends on cce_pkg for the length width.
interface cce_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       message_last;

    modport source (output valid, output in_byte, output message_last, input ready);
    modport sink   (input valid, input in_byte, input message_last, output ready);
endinterface

interface cce_out_if;
    logic                      valid;
    logic                      ready;
    logic [7:0]                out_char;
    logic                      char_valid;
    logic                      run_last;
    logic                      message_done;
    logic [cce_pkg::LEN_W-1:0] out_length;

    modport source (output valid, output out_char, output char_valid, output run_last,
                    output message_done, output out_length, input ready);
    modport sink   (input valid, input out_char, input char_valid, input run_last,
                    input message_done, input out_length, output ready);
endinterface

// ===== hdl/control_char_escape_stream_core.sv =====
// Top level of the control character escape stream block.
// Depends on cce_pkg, cce_in_if, cce_out_if, cce_expand and cce_emit.
//
// Usage:
//   i_in carries raw message bytes with message_last on the final byte.
//   o_out carries one transaction per output character: printable bytes pass
//   through, other bytes become <MNEMONIC>, <DEL> or <hh>. A message whose
//   last byte was dropped or did not fit ends with a length-only transaction
//   (char_valid 0) that reports the total.
//   i_cfg_we / i_cfg_wdata set the buffer size (reset 256); write it only
//   while the block is idle. Capacity is buffer size minus one, zero for size 0.
//   The first character of a byte goes from the emitter's sequence register
//   to the result register that drives o_out. The emitter gives one output
//   transaction per cycle while the receiver is ready; a byte holds it until
//   all characters of its expansion (1 to 5) are sent, so single-character
//   bytes stream at one per cycle; a dropped non-final byte loads nothing.
//   Reset clears the message count, the truncation flag and both valid
//   stages. When the receiver stalls, the result register holds its
//   transaction and the emitter and input side stall behind it.
module control_char_escape_stream_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    cce_in_if.sink                    i_in,
    cce_out_if.source                 o_out,
    input  logic                      i_cfg_we,
    input  logic [cce_pkg::LEN_W-1:0] i_cfg_wdata
);

    cce_pkg::t_load load;
    logic           seq_ready;

    cce_expand u_expand (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_seq_ready (seq_ready),
        .o_load      (load)
    );

    cce_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .o_seq_ready (seq_ready),
        .o_out       (o_out)
    );

endmodule

// ===== hdl/cce_expand.sv =====
// Input side: buffer size register, message count, truncation flag and fit check.
// Expands accepted bytes; fitting ones and a dropped last byte send a load record.
// Depends on cce_pkg and cce_in_if.
module cce_expand (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    cce_in_if.sink                    i_in,
    input  logic                      i_cfg_we,
    input  logic [cce_pkg::LEN_W-1:0] i_cfg_wdata,
    input  logic                      i_seq_ready,
    output cce_pkg::t_load            o_load
);

    logic [cce_pkg::LEN_W-1:0] r_buffer_size, n_buffer_size;
    logic [cce_pkg::LEN_W-1:0] r_count, n_count;
    logic                      r_trunc, n_trunc;

    cce_pkg::t_expansion       exp_w;
    logic [cce_pkg::LEN_W-1:0] cap;
    logic [cce_pkg::LEN_W:0]   sum;
    logic                      accept;
    logic                      fit;

    assign i_in.ready = i_seq_ready;
    assign accept     = i_in.valid && i_in.ready;
    assign exp_w      = cce_pkg::expand(i_in.in_byte);
    assign cap        = (r_buffer_size == '0) ? '0 : r_buffer_size - 1'b1;
    assign sum        = {1'b0, r_count} + (cce_pkg::LEN_W + 1)'(exp_w.len);
    assign fit        = !r_trunc && (sum <= {1'b0, cap});

    always_comb begin
        n_buffer_size = i_cfg_we ? i_cfg_wdata : r_buffer_size;
        n_count       = r_count;
        n_trunc       = r_trunc;
        o_load.load   = 1'b0;
        o_load.seq    = exp_w.seq;
        o_load.len    = exp_w.len;
        o_load.report = 1'b0;
        o_load.last   = i_in.message_last;
        o_load.base   = r_count;
        if (accept) begin
            if (fit) begin
                o_load.load = 1'b1;
                n_count     = sum[cce_pkg::LEN_W-1:0];
            end else begin
                n_trunc = 1'b1;
                if (i_in.message_last) begin
                    o_load.load   = 1'b1;
                    o_load.report = 1'b1;
                    o_load.seq    = '0;
                    o_load.len    = cce_pkg::CNT_W'(1);
                end
            end
            if (i_in.message_last) begin
                n_count = '0;
                n_trunc = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= cce_pkg::BUF_SIZE_RST;
            r_count       <= '0;
            r_trunc       <= 1'b0;
        end else begin
            r_buffer_size <= n_buffer_size;
            r_count       <= n_count;
            r_trunc       <= n_trunc;
        end
    end

endmodule

// ===== hdl/cce_emit.sv =====
// Output side: holds one expansion, sends one character per cycle while
// o_out is ready, via a result register. Needs cce_pkg and cce_out_if.
module cce_emit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cce_pkg::t_load i_load,
    output logic           o_seq_ready,
    cce_out_if.source      o_out
);

    logic                        r_busy, n_busy;
    logic [cce_pkg::SEQ_W-1:0]   r_seq, n_seq;
    logic [cce_pkg::CNT_W-1:0]   r_left, n_left;
    logic                        r_report, n_report;
    logic                        r_last, n_last;
    logic [cce_pkg::LEN_W-1:0]   r_pos, n_pos;

    logic                        r_ovalid, n_ovalid;
    logic [7:0]                  r_char, n_char;
    logic                        r_cv, n_cv;
    logic                        r_rl, n_rl;
    logic                        r_md, n_md;
    logic [cce_pkg::LEN_W-1:0]   r_olen, n_olen;

    logic emit;
    logic final_one;

    assign emit        = r_busy && (!r_ovalid || o_out.ready);
    assign final_one   = (r_left == cce_pkg::CNT_W'(1));
    assign o_seq_ready = !r_busy || (emit && final_one);

    always_comb begin
        n_busy   = r_busy;
        n_seq    = r_seq;
        n_left   = r_left;
        n_report = r_report;
        n_last   = r_last;
        n_pos    = r_pos;
        n_ovalid = r_ovalid;
        n_char   = r_char;
        n_cv     = r_cv;
        n_rl     = r_rl;
        n_md     = r_md;
        n_olen   = r_olen;
        if (emit) begin
            n_ovalid = 1'b1;
            n_char   = r_seq[7:0];
            n_cv     = !r_report;
            n_rl     = final_one;
            n_md     = final_one && r_last;
            n_olen   = r_report ? r_pos : r_pos + 1'b1;
            n_pos    = r_report ? r_pos : r_pos + 1'b1;
            n_seq    = r_seq >> 8;
            n_left   = r_left - 1'b1;
            if (final_one) begin
                n_busy = 1'b0;
            end
        end else if (o_out.ready) begin
            n_ovalid = 1'b0;
        end
        if (i_load.load) begin
            n_busy   = 1'b1;
            n_seq    = i_load.seq;
            n_left   = i_load.len;
            n_report = i_load.report;
            n_last   = i_load.last;
            n_pos    = i_load.base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
        end
        r_seq    <= n_seq;
        r_left   <= n_left;
        r_report <= n_report;
        r_last   <= n_last;
        r_pos    <= n_pos;
        r_char   <= n_char;
        r_cv     <= n_cv;
        r_rl     <= n_rl;
        r_md     <= n_md;
        r_olen   <= n_olen;
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.out_char     = r_char;
    assign o_out.char_valid   = r_cv;
    assign o_out.run_last     = r_rl;
    assign o_out.message_done = r_md;
    assign o_out.out_length   = r_olen;

endmodule

// ===== sim/testbench.sv =====
// Testbench for control_char_escape_stream_core: streams messages through the escaper
// and checks every output character and length report against a built-in predictor.
// Depends on cce_pkg and the cce_in_if / cce_out_if channel interfaces.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [7:0]                ch;
        logic                      ch_valid;
        logic                      run_last;
        logic                      msg_done;
        logic [cce_pkg::LEN_W-1:0] length;
    } t_out_char;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [cce_pkg::LEN_W-1:0] i_cfg_wdata;

    cce_in_if  in_ch ();
    cce_out_if out_ch ();

    control_char_escape_stream_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    string ctrl_mnem [32] = '{
        "NUL", "SOH", "STX", "ETX", "EOT", "ENQ", "ACK", "BEL",
        "BS",  "HT",  "LF",  "VT",  "FF",  "CR",  "SO",  "SI",
        "DLE", "DC1", "DC2", "DC3", "DC4", "NAK", "SYN", "ETB",
        "CAN", "EM",  "SUB", "ESC", "FS",  "GS",  "RS",  "US"
    };

    t_out_char                 expected_chars [$];
    logic [cce_pkg::LEN_W-1:0] buf_size     = cce_pkg::BUF_SIZE_RST;
    logic [cce_pkg::LEN_W-1:0] msg_len      = '0;
    logic                      msg_dropped  = 1'b0;
    int                        idle_pct     = 22;
    bit                        hold_off_req = 1'b0;
    int                        mismatch_count = 0;
    int                        quiet_cycles   = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [7:0] hex_lower(input logic [3:0] d);
        if (d < 4'd10) begin
            return 8'h30 | {4'h0, d};
        end
        return 8'h61 + {4'h0, d} - 8'd10;
    endfunction

    task automatic render_byte(input logic [7:0] b, input logic last);
        logic [7:0] seq [0:4];
        int         n;
        int         k;
        int         cap;
        int         emitted;
        string      m;
        t_out_char  r;
        n       = 0;
        emitted = 0;
        if (b == 8'h09 || b == 8'h0A || b == 8'h0D || (b >= 8'h20 && b <= 8'h7E)) begin
            seq[0] = b;
            n      = 1;
        end else begin
            seq[0] = "<";
            n      = 1;
            if (b < 8'h20) begin
                m = ctrl_mnem[b[4:0]];
                for (k = 0; k < m.len(); k++) begin
                    seq[n] = m[k];
                    n++;
                end
            end else if (b == 8'h7F) begin
                seq[1] = "D";
                seq[2] = "E";
                seq[3] = "L";
                n      = 4;
            end else begin
                seq[1] = hex_lower(b[7:4]);
                seq[2] = hex_lower(b[3:0]);
                n      = 3;
            end
            seq[n] = ">";
            n++;
        end
        cap = (buf_size == '0) ? 0 : int'(buf_size) - 1;
        if (!msg_dropped) begin
            if (int'(msg_len) + n <= cap) begin
                for (k = 0; k < n; k++) begin
                    msg_len    = msg_len + 1'b1;
                    r.ch       = seq[k];
                    r.ch_valid = 1'b1;
                    r.run_last = (k == n - 1);
                    r.msg_done = (k == n - 1) && last;
                    r.length   = msg_len;
                    expected_chars.push_back(r);
                end
                emitted = n;
            end else begin
                msg_dropped = 1'b1;
            end
        end
        if (last) begin
            if (emitted == 0) begin
                r.ch       = 8'h00;
                r.ch_valid = 1'b0;
                r.run_last = 1'b1;
                r.msg_done = 1'b1;
                r.length   = msg_len;
                expected_chars.push_back(r);
            end
            msg_len     = '0;
            msg_dropped = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input logic [cce_pkg::LEN_W-1:0] want,
                               input logic [cce_pkg::LEN_W-1:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            render_byte(in_ch.in_byte, in_ch.message_last);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out_char e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_chars.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected transaction, expected none, %s %h length %0d",
                             $time, "actual char", out_ch.out_char, out_ch.out_length);
                end
            end else begin
                e = expected_chars.pop_front();
                check_field("out_char", cce_pkg::LEN_W'(e.ch),
                            cce_pkg::LEN_W'(out_ch.out_char));
                check_field("char_valid", cce_pkg::LEN_W'(e.ch_valid),
                            cce_pkg::LEN_W'(out_ch.char_valid));
                check_field("run_last", cce_pkg::LEN_W'(e.run_last),
                            cce_pkg::LEN_W'(out_ch.run_last));
                check_field("message_done", cce_pkg::LEN_W'(e.msg_done),
                            cce_pkg::LEN_W'(out_ch.message_done));
                check_field("out_length", e.length, out_ch.out_length);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : receiver
        int held;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) begin
                    out_ch.ready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.in_byte      <= b;
        in_ch.message_last <= last;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic set_buffer_size(input logic [cce_pkg::LEN_W-1:0] size);
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_chars.size() != 0);
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= size;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        buf_size     = size;
    endtask

    function automatic logic [7:0] random_byte();
        unique case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: return 8'($urandom_range(8'h20, 8'h7E));
            8, 9: begin
                unique case ($urandom_range(0, 2))
                    0:       return 8'h09;
                    1:       return 8'h0A;
                    default: return 8'h0D;
                endcase
            end
            10, 11, 12, 13: return 8'($urandom_range(8'h00, 8'h1F));
            14:             return 8'h7F;
            default:        return 8'($urandom_range(8'h80, 8'hFF));
        endcase
    endfunction

    function automatic logic [cce_pkg::LEN_W-1:0] random_size();
        unique case ($urandom_range(0, 9))
            0:       return '0;
            1:       return cce_pkg::LEN_W'(1);
            2:       return cce_pkg::LEN_W'($urandom_range(2, 8));
            3, 4:    return cce_pkg::LEN_W'($urandom_range(9, 40));
            5:       return cce_pkg::LEN_W'(256);
            6:       return '1;
            7:       return cce_pkg::LEN_W'($urandom_range(0, 65535));
            default: return cce_pkg::LEN_W'($urandom_range(41, 120));
        endcase
    endfunction

    task automatic test_pass_through;
        send_byte(8'h20, 1'b0);
        send_byte("A", 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h09, 1'b0);
        send_byte(8'h0A, 1'b0);
        send_byte(8'h0D, 1'b1);
    endtask

    task automatic test_escapes;
        send_byte(8'h00, 1'b0);
        send_byte(8'h08, 1'b0);
        send_byte(8'h1B, 1'b0);
        send_byte(8'h1F, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_truncation;
        set_buffer_size(cce_pkg::LEN_W'(6));
        send_byte("a", 1'b0);
        send_byte("b", 1'b0);
        send_byte(8'h1B, 1'b0);
        send_byte("c", 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte("x", 1'b1);
        set_buffer_size(cce_pkg::LEN_W'(1));
        send_byte("A", 1'b1);
    endtask

    task automatic test_zero_buffer;
        set_buffer_size('0);
        send_byte("A", 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_random_messages;
        int sent;
        int msgs;
        int len;
        int k;
        sent = 0;
        msgs = 0;
        while (sent < 280) begin
            if (msgs % 6 == 0) begin
                set_buffer_size(random_size());
            end
            idle_pct = (msgs >= 20 && msgs < 32) ? 0 : 22;
            len = $urandom_range(1, 14);
            for (k = 0; k < len; k++) begin
                send_byte(random_byte(), k == len - 1);
                sent++;
            end
            msgs++;
        end
        idle_pct = 22;
    endtask

    task automatic test_backpressure;
        int k;
        set_buffer_size('1);
        hold_off_req = 1'b1;
        for (k = 0; k < 40; k++) begin
            send_byte(random_byte(), k == 39);
        end
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_wdata        <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.in_byte      <= '0;
        in_ch.message_last <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_pass_through();
        test_escapes();
        test_truncation();
        test_zero_buffer();
        test_random_messages();
        test_backpressure();

        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_chars.size() != 0);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== control_char_escape_stream_core.f =====
hdl/cce_pkg.sv
hdl/cce_if.sv
hdl/cce_expand.sv
hdl/cce_emit.sv
hdl/control_char_escape_stream_core.sv
sim/testbench.sv
